// ===== rtl/core/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, command and status codes, control and status structs and
// the ring index helper for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Queue geometry.
   localparam int DEPTH  = 16;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   // Field widths of the channels.
   localparam int DATA_W = 32;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   // Command codes.
   localparam logic [CMD_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [CMD_W-1:0] OP_PUSH_BACK  = 2'd1;
   localparam logic [CMD_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [CMD_W-1:0] OP_POP_BACK   = 2'd3;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the incoming item
      logic execute;   // evaluate the latched command this cycle
      logic accept;    // the command is legal and changes the queue
   } dq_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [CMD_W-1:0] op;
      logic             full;
      logic             empty;
   } dq_stat_type;

   // Ring index plus an offset of at most DEPTH, wrapped modulo DEPTH.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] idx,
                                                 input logic [CNT_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = {{(SUM_W - IDX_W){1'b0}}, idx} + {1'b0, off};
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== rtl/core/dq_if.sv =====
// ----------------------------------------------------------------------------
// dq_if
// Valid/ready channel interfaces for command items and result items.
// ----------------------------------------------------------------------------

// Command channel: one item per queue command.
interface dq_req_if;
   logic                                valid;
   logic                                ready;
   logic [dq_pkg::CMD_W-1:0]            cmd;
   logic signed [dq_pkg::DATA_W-1:0]    data_in;

   modport source (output valid, output cmd, output data_in, input ready);
   modport sink   (input valid, input cmd, input data_in, output ready);
endinterface

// Result channel: one item per command.
interface dq_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dq_pkg::DATA_W-1:0]    data_out;
   logic [dq_pkg::STAT_W-1:0]           status;
   logic [dq_pkg::OCC_W-1:0]            occupancy;

   modport source (output valid, output data_out, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input data_out, input status, input occupancy,
                   output ready);
endinterface

// ===== rtl/core/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer for the queue: takes one command item, has the datapath execute
// it against the ring store, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  dq_pkg::dq_stat_type  stat,
   output dq_pkg::dq_ctl_type   ctl
);
   import dq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       is_push;

   // Pushes need room, pops need a word.
   assign is_push = (stat.op == OP_PUSH_FRONT) || (stat.op == OP_PUSH_BACK);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Handshakes and datapath commands.
   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = (state_ff == S_RESP);
   assign ctl.capture = req_valid && req_ready;
   assign ctl.execute = (state_ff == S_EXEC);
   assign ctl.accept  = is_push ? !stat.full : !stat.empty;

`ifndef SYNTHESIS
   // A result only follows execution of a command.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_EXEC)
      else $error("result shown without an executed command");

   // A push is never carried out on a full queue.
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (ctl.execute && ctl.accept && is_push) |-> !stat.full)
      else $error("push accepted on full queue");

   // A pop is never carried out on an empty queue.
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (ctl.execute && ctl.accept && !is_push) |-> !stat.empty)
      else $error("pop accepted on empty queue");

   // Only one side of the block is open at a time.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input and result handshakes open together");
`endif

endmodule

// ===== rtl/core/dq_dpath.sv =====
// ----------------------------------------------------------------------------
// dq_dpath
// Ring store, front index and entry count of the queue, plus the result
// registers for one command.
// ----------------------------------------------------------------------------
module dq_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  dq_pkg::dq_ctl_type                ctl,
   output dq_pkg::dq_stat_type               stat,
   input  logic [dq_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [dq_pkg::DATA_W-1:0]  req_data_in,
   output logic signed [dq_pkg::DATA_W-1:0]  rsp_data_out,
   output logic [dq_pkg::STAT_W-1:0]         rsp_status,
   output logic [dq_pkg::OCC_W-1:0]          rsp_occupancy
);
   import dq_pkg::*;

   // Ring store, no reset: entries are only read after being written.
   logic [DATA_W-1:0]  mem [DEPTH];

   logic [CMD_W-1:0]   op_ff;
   logic [DATA_W-1:0]  word_ff;
   logic [IDX_W-1:0]   front_ff;
   logic [IDX_W-1:0]   front_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic [STAT_W-1:0]  status_ff;
   logic [STAT_W-1:0]  status_in;
   logic               pop_ok_ff;
   logic [DATA_W-1:0]  rd_data_ff;
   logic [IDX_W-1:0]   slot;
   logic               wr_en;
   logic               rd_en;

   assign stat.op    = op_ff;
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);

   // Latch the command item.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff   <= req_cmd;
         word_ff <= req_data_in;
      end
   end

   // Slot selection and index/count updates for the latched command.
   always_comb begin
      slot      = front_ff;
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      status_in = ST_OK;
      case (op_ff)
         OP_PUSH_FRONT: begin
            slot = ring_add(front_ff, CNT_W'(DEPTH - 1));
            if (ctl.accept) begin
               front_in = slot;
               count_in = count_ff + 1'b1;
               wr_en    = ctl.execute;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_PUSH_BACK: begin
            slot = ring_add(front_ff, count_ff);
            if (ctl.accept) begin
               count_in = count_ff + 1'b1;
               wr_en    = ctl.execute;
            end else begin
               status_in = ST_FULL;
            end
         end
         OP_POP_FRONT: begin
            slot = front_ff;
            if (ctl.accept) begin
               front_in = ring_add(front_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
               rd_en    = ctl.execute;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         OP_POP_BACK: begin
            slot = ring_add(front_ff, count_ff - 1'b1);
            if (ctl.accept) begin
               count_in = count_ff - 1'b1;
               rd_en    = ctl.execute;
            end else begin
               status_in = ST_EMPTY;
            end
         end
         default: begin
            slot = front_ff;
         end
      endcase
   end

   // Queue pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (ctl.execute) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   // Result status, held until the next command executes.
   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         status_ff <= status_in;
         pop_ok_ff <= rd_en;
      end
   end

   // Ring store with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot] <= word_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[slot];
      end
   end

   assign rsp_data_out  = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = OCC_W'(count_ff);

`ifndef SYNTHESIS
   // The count never exceeds the ring size.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above depth");

   // The pointers move only when a command executes.
   a_ptr_hold: assert property (@(posedge clock)
      (!reset && !$past(reset) && !$past(ctl.execute)) |->
         ($stable(count_ff) && $stable(front_ff)))
      else $error("queue pointers changed without a command");

   // A rejected command leaves the count unchanged.
   a_reject_hold: assert property (@(posedge clock) disable iff (reset)
      (ctl.execute && !ctl.accept) |=> $stable(count_ff))
      else $error("rejected command changed the queue");
`endif

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed words in a ring store.
// A command is captured, then executed with the ring store access and registered
// read, then its result is held until it is taken; one command is in flight at a
// time, so a new command is taken only after the last result is taken, and any
// result stall holds it back. Synchronous active-high reset empties the queue; store contents are kept.
// ----------------------------------------------------------------------------
module double_ended_queue (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_if,
   dq_rsp_if.source  rsp_if
);
   import dq_pkg::*;

   dq_ctl_type   ctl;
   dq_stat_type  stat;

   // Sequencer.
   dq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Ring store and pointers.
   dq_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_cmd       (req_if.cmd),
      .req_data_in   (req_if.data_in),
      .rsp_data_out  (rsp_if.data_out),
      .rsp_status    (rsp_if.status),
      .rsp_occupancy (rsp_if.occupancy)
   );

endmodule

// ===== dv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the double-ended queue. Commands are driven through
// the request channel with random gaps while the result channel stalls at
// random. A scoreboard keeps its own copy of the ring, predicts every result,
// and checks each returned item in order.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
   import dq_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;

   // One predicted result item.
   typedef struct {
      logic signed [DATA_W-1:0] word;
      logic [STAT_W-1:0]        status;
      logic [OCC_W-1:0]         occupancy;
   } deque_result_type;

   // Scoreboard: mirrors the ring and queues the predicted results.
   class deque_scoreboard;
      logic signed [DATA_W-1:0] slots [DEPTH];
      int unsigned              head;
      int unsigned              held;
      deque_result_type         pending_results [$];
      int                       mismatches;

      function new();
         head = 0;
         held = 0;
         mismatches = 0;
      endfunction

      // Applies one accepted command to the mirror and queues its result.
      function void note_command(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] word);
         deque_result_type res;
         res.word = '0;
         res.status = ST_OK;
         case (op)
            OP_PUSH_FRONT: begin
               if (held >= DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  head = (head + DEPTH - 1) % DEPTH;
                  slots[head] = word;
                  held++;
               end
            end
            OP_PUSH_BACK: begin
               if (held >= DEPTH) begin
                  res.status = ST_FULL;
               end else begin
                  slots[(head + held) % DEPTH] = word;
                  held++;
               end
            end
            OP_POP_FRONT: begin
               if (held == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.word = slots[head];
                  head = (head + 1) % DEPTH;
                  held--;
               end
            end
            default: begin
               if (held == 0) begin
                  res.status = ST_EMPTY;
               end else begin
                  res.word = slots[(head + held - 1) % DEPTH];
                  held--;
               end
            end
         endcase
         res.occupancy = OCC_W'(held);
         pending_results.push_back(res);
      endfunction

      // Compares one returned item with the oldest prediction.
      function void check_result(logic signed [DATA_W-1:0] word, logic [STAT_W-1:0] status,
                                 logic [OCC_W-1:0] occupancy);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            $error("result item with no command outstanding");
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (word !== want.word) begin
            $error("data_out mismatch: expected %0d, actual %0d", want.word, word);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            mismatches++;
         end
         if (occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d", want.occupancy, occupancy);
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   gap_pct;
   int   stall_pct;
   int   stall_left;

   deque_scoreboard sb;

   dq_req_if req_ch ();
   dq_rsp_if rsp_ch ();

   double_ended_queue u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // Clock with a 20 ns period.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Known values on every input from time zero.
   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd = OP_PUSH_FRONT;
      req_ch.data_in = '0;
      rsp_ch.ready = 1'b0;
      stall_left = 0;
      stall_pct = 0;
      gap_pct = 0;
      sb = new();
   end

   // Result side: ready drops in random bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Result monitor: every accepted result item is checked.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result(rsp_ch.data_out, rsp_ch.status, rsp_ch.occupancy);
      end
   end

   // Watchdog on the total run length.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Presents one command and waits until the queue takes it.
   task automatic send_command(logic [CMD_W-1:0] op, logic signed [DATA_W-1:0] word);
      req_ch.valid <= 1'b1;
      req_ch.cmd <= op;
      req_ch.data_in <= word;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_command(op, word);
   endtask

   // Holds the command channel idle for a number of cycles.
   task automatic pause_sender(int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender gap after an item, as often as the current phase allows.
   task automatic maybe_pause();
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         pause_sender($urandom_range(1, 6));
      end
   endtask

   // Stimulus: directed corner cases, then phases of random commands.
   initial begin
      int                       push_pct;
      logic [CMD_W-1:0]         op;
      logic signed [DATA_W-1:0] word;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      gap_pct = 30;
      stall_pct = 30;

      // Pops on an empty queue at both ends.
      send_command(OP_POP_FRONT, 32'sh7FFF_FFFF);
      maybe_pause();
      send_command(OP_POP_BACK, -32'sd1);
      maybe_pause();

      // Extreme words at both ends, then taken back out from the same ends.
      send_command(OP_PUSH_BACK, 32'sh7FFF_FFFF);
      maybe_pause();
      send_command(OP_PUSH_FRONT, 32'sh8000_0000);
      maybe_pause();
      send_command(OP_POP_BACK, '0);
      maybe_pause();
      send_command(OP_POP_FRONT, '0);
      maybe_pause();

      // Fill the ring from both ends so the front index wraps below zero.
      for (int i = 0; i < DEPTH; i++) begin
         op = i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT;
         word = i[0] ? ~(32'sd1 <<< i) : (32'sd1 <<< (i + 16));
         send_command(op, word);
         maybe_pause();
      end

      // Pushes on a full queue at both ends, then one pop.
      send_command(OP_PUSH_BACK, -32'sd1);
      maybe_pause();
      send_command(OP_PUSH_FRONT, '0);
      maybe_pause();
      send_command(OP_POP_FRONT, '0);
      maybe_pause();

      // Random phases: push bias swings the queue between empty and full.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: push_pct = 75;
            1: push_pct = 25;
            2: push_pct = 50;
            3: push_pct = 90;
            4: push_pct = 10;
            default: push_pct = 50;
         endcase
         if (ph == 5) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            gap_pct = $urandom_range(0, 40);
            stall_pct = $urandom_range(0, 40);
         end
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 99) < push_pct) begin
               op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else begin
               op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            end
            case ($urandom_range(0, 7))
               0: word = 32'sh7FFF_FFFF;
               1: word = 32'sh8000_0000;
               2: word = $urandom_range(0, 15);
               default: word = $urandom;
            endcase
            send_command(op, word);
            maybe_pause();
         end
      end
      req_ch.valid <= 1'b0;

      // Drain outstanding results, then watch for stray ones.
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
